// ===== hdl/gdad_pkg.sv =====
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and calendar helpers of the date add-days unit.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned OffsetW = 32;
  localparam int unsigned CountW  = 22;

  localparam logic [YearW-1:0]   MaxYear         = YearW'(9999);
  localparam logic [YearW-1:0]   YearsPerCentury = YearW'(100);
  localparam logic [MonthW-1:0]  MonthsPerYear   = MonthW'(12);
  localparam logic [DayW-1:0]    LastDayOfYear   = DayW'(31);
  localparam logic [6:0]         LastYearOfCent  = 7'd99;
  localparam logic [OffsetW-1:0] LastSerial      = OffsetW'(3652058);

  // Step direction codes
  localparam logic DirFwd = 1'b0;
  localparam logic DirBwd = 1'b1;

  typedef struct packed {
    logic load;     // take a fresh date from the load port
    logic advance;  // move one day in the direction below
    logic dir;
  } step_ctrl_t;

  typedef struct packed {
    logic            at_max;  // 9999-12-31
    logic            at_min;  // 0001-01-01
    logic [DayW-1:0] mlen;    // length of the current month
  } step_stat_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = DayW'(31);
    case (m)
      MonthW'(2):  len = leap ? DayW'(29) : DayW'(28);
      MonthW'(4),
      MonthW'(6),
      MonthW'(9),
      MonthW'(11): len = DayW'(30);
      default:     len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/gdad_if.sv =====
// ----------------------------------------------------------------------------
// gdad_req_if / gdad_rsp_if
// Valid/ready channels carrying date requests and results.
// ----------------------------------------------------------------------------
interface gdad_req_if;
  logic                              valid;
  logic                              ready;
  logic [gdad_pkg::YearW-1:0]        year;
  logic [gdad_pkg::MonthW-1:0]       month;
  logic [gdad_pkg::DayW-1:0]         day;
  logic signed [gdad_pkg::OffsetW-1:0] offset_days;

  modport source (output valid, year, month, day, offset_days, input ready);
  modport sink   (input valid, year, month, day, offset_days, output ready);
endinterface

interface gdad_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [gdad_pkg::YearW-1:0]  new_year;
  logic [gdad_pkg::MonthW-1:0] new_month;
  logic [gdad_pkg::DayW-1:0]   new_day;
  logic                        ok;

  modport source (output valid, new_year, new_month, new_day, ok, input ready);
  modport sink   (input valid, new_year, new_month, new_day, ok, output ready);
endinterface

// ===== hdl/gdad_split.sv =====
// ----------------------------------------------------------------------------
// gdad_split
// Split a year into year-of-century and century mod 4 by repeated subtract.
// ----------------------------------------------------------------------------
module gdad_split (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gdad_pkg::YearW-1:0] year_i,
  output logic                       done_o,
  output logic [6:0]                 ymod100_o,
  output logic [1:0]                 cmod4_o
);

  logic                       busy_q, busy_d;
  logic [gdad_pkg::YearW-1:0] rem_q, rem_d;
  logic [1:0]                 cent_q, cent_d;
  logic                       ge_cent;

  assign ge_cent = (rem_q >= gdad_pkg::YearsPerCentury);

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    cent_d = cent_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = year_i;
      cent_d = 2'd0;
    end else if (busy_q) begin
      if (ge_cent) begin
        rem_d  = rem_q - gdad_pkg::YearsPerCentury;
        cent_d = cent_q + 2'd1;
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    cent_q <= cent_d;
  end

  assign done_o    = busy_q && !ge_cent;
  assign ymod100_o = rem_q[6:0];
  assign cmod4_o   = cent_q;

endmodule

// ===== hdl/gdad_step.sv =====
// ----------------------------------------------------------------------------
// gdad_step
// Date register that moves one calendar day per advance, either direction.
// ----------------------------------------------------------------------------
module gdad_step (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gdad_pkg::step_ctrl_t        ctrl_i,
  input  logic [gdad_pkg::YearW-1:0]  year_i,
  input  logic [gdad_pkg::MonthW-1:0] month_i,
  input  logic [gdad_pkg::DayW-1:0]   day_i,
  input  logic [6:0]                  ymod100_i,
  input  logic [1:0]                  cmod4_i,
  output logic [gdad_pkg::YearW-1:0]  year_o,
  output logic [gdad_pkg::MonthW-1:0] month_o,
  output logic [gdad_pkg::DayW-1:0]   day_o,
  output gdad_pkg::step_stat_t        stat_o
);

  logic [gdad_pkg::YearW-1:0]  y_q, y_d;
  logic [gdad_pkg::MonthW-1:0] m_q, m_d;
  logic [gdad_pkg::DayW-1:0]   d_q, d_d;
  logic [6:0]                  ym_q, ym_d;
  logic [1:0]                  cm_q, cm_d;
  logic                        leap;
  logic [gdad_pkg::DayW-1:0]   mlen;
  logic [gdad_pkg::MonthW-1:0] m_prev;

  // Leap by 4/100/400: century years look at the century count instead
  assign leap   = (ym_q != 7'd0) ? (y_q[1:0] == 2'd0) : (cm_q == 2'd0);
  assign mlen   = gdad_pkg::month_len(m_q, leap);
  assign m_prev = m_q - 4'd1;

  always_comb begin
    y_d  = y_q;
    m_d  = m_q;
    d_d  = d_q;
    ym_d = ym_q;
    cm_d = cm_q;
    if (ctrl_i.load) begin
      y_d  = year_i;
      m_d  = month_i;
      d_d  = day_i;
      ym_d = ymod100_i;
      cm_d = cmod4_i;
    end else if (ctrl_i.advance) begin
      if (ctrl_i.dir == gdad_pkg::DirFwd) begin
        if (d_q < mlen) begin
          d_d = d_q + 5'd1;
        end else begin
          d_d = 5'd1;
          if (m_q < gdad_pkg::MonthsPerYear) begin
            m_d = m_q + 4'd1;
          end else begin
            m_d = 4'd1;
            y_d = y_q + 14'd1;
            if (ym_q == gdad_pkg::LastYearOfCent) begin
              ym_d = 7'd0;
              cm_d = cm_q + 2'd1;
            end else begin
              ym_d = ym_q + 7'd1;
            end
          end
        end
      end else begin
        if (d_q > 5'd1) begin
          d_d = d_q - 5'd1;
        end else if (m_q > 4'd1) begin
          m_d = m_prev;
          d_d = gdad_pkg::month_len(m_prev, leap);
        end else begin
          m_d = gdad_pkg::MonthsPerYear;
          d_d = gdad_pkg::LastDayOfYear;
          y_d = y_q - 14'd1;
          if (ym_q == 7'd0) begin
            ym_d = gdad_pkg::LastYearOfCent;
            cm_d = cm_q - 2'd1;
          end else begin
            ym_d = ym_q - 7'd1;
          end
        end
      end
    end
  end

  // Date registers are payload and carry no reset
  always_ff @(posedge clk_i) begin
    y_q  <= y_d;
    m_q  <= m_d;
    d_q  <= d_d;
    ym_q <= ym_d;
    cm_q <= cm_d;
  end

  logic loaded_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
    end else if (ctrl_i.load) begin
      loaded_q <= 1'b1;
    end
  end

  assign year_o        = y_q;
  assign month_o       = m_q;
  assign day_o         = d_q;
  assign stat_o.mlen   = mlen;
  assign stat_o.at_max = loaded_q && (y_q == gdad_pkg::MaxYear) &&
                         (m_q == gdad_pkg::MonthsPerYear) &&
                         (d_q == gdad_pkg::LastDayOfYear);
  assign stat_o.at_min = loaded_q && (y_q == 14'd1) && (m_q == 4'd1) && (d_q == 5'd1);

endmodule

// ===== hdl/gregorian_date_add_days_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_add_days_unit
// Adds a signed day count to a Gregorian date by walking one day per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries a request: year, month, day and a signed offset_days.
//   rsp_o returns one result per request: new_year, new_month, new_day, ok.
//   ok is 0 when the start date is invalid or the walk would leave years
//   1 to 9999; the request date is then echoed unchanged.
// Sequence:
//   A request with a bad start date or an offset beyond the whole calendar
//   span goes straight to the result. Otherwise the year split runs (one
//   subtract of 100 per cycle), StCheck checks the day against the month
//   length, and the day walk moves |offset_days| days, one day per cycle
//   through the single day stepper.
// Throughput:
//   One request at a time; req_i.ready is high only while no request is
//   being worked on.
// Reset: clears the sequencer and the result valid; nothing else to set up.
// Stall: a finished result waits in the output register while rsp_o.ready is
//   low, and a new request may already be taken and worked on meanwhile.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  gdad_req_if.sink        req_i,
  gdad_rsp_if.source      rsp_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSplit = 3'd1;
  localparam logic [2:0] StCheck = 3'd2;
  localparam logic [2:0] StWalk  = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  logic [2:0] state_q, state_d;

  // Held request
  logic [gdad_pkg::YearW-1:0]  in_y_q, in_y_d;
  logic [gdad_pkg::MonthW-1:0] in_m_q, in_m_d;
  logic [gdad_pkg::DayW-1:0]   in_d_q, in_d_d;
  logic                        dir_q, dir_d;
  logic [gdad_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        ok_q, ok_d;

  // Output register
  logic                        rsp_valid_q, rsp_valid_d;
  logic [gdad_pkg::YearW-1:0]  rsp_y_q, rsp_y_d;
  logic [gdad_pkg::MonthW-1:0] rsp_m_q, rsp_m_d;
  logic [gdad_pkg::DayW-1:0]   rsp_d_q, rsp_d_d;
  logic                        rsp_ok_q, rsp_ok_d;

  logic                        req_fire;
  logic [gdad_pkg::OffsetW-1:0] mag;
  logic                        bad_start;
  logic                        too_far;
  logic                        out_free;

  logic                        split_start;
  logic                        split_done;
  logic [6:0]                  split_ymod100;
  logic [1:0]                  split_cmod4;

  gdad_pkg::step_ctrl_t        step_ctrl;
  gdad_pkg::step_stat_t        step_stat;
  logic [gdad_pkg::YearW-1:0]  step_y;
  logic [gdad_pkg::MonthW-1:0] step_m;
  logic [gdad_pkg::DayW-1:0]   step_d;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;

  // Magnitude of the offset; the most negative value maps to 2^31 unsigned
  assign mag = req_i.offset_days[gdad_pkg::OffsetW-1] ?
               (~req_i.offset_days + 32'd1) : req_i.offset_days;

  assign bad_start = (req_i.year == 14'd0) || (req_i.year > gdad_pkg::MaxYear) ||
                     (req_i.month == 4'd0) || (req_i.month > gdad_pkg::MonthsPerYear) ||
                     (req_i.day == 5'd0);
  // No walk longer than the full calendar span can stay in range
  assign too_far   = (mag > gdad_pkg::LastSerial);

  assign out_free  = !rsp_valid_q || rsp_o.ready;

  assign split_start = req_fire && !bad_start && !too_far;

  gdad_split u_split (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (split_start),
    .year_i    (req_i.year),
    .done_o    (split_done),
    .ymod100_o (split_ymod100),
    .cmod4_o   (split_cmod4)
  );

  gdad_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (step_ctrl),
    .year_i    (in_y_q),
    .month_i   (in_m_q),
    .day_i     (in_d_q),
    .ymod100_i (split_ymod100),
    .cmod4_i   (split_cmod4),
    .year_o    (step_y),
    .month_o   (step_m),
    .day_o     (step_d),
    .stat_o    (step_stat)
  );

  always_comb begin
    state_d   = state_q;
    in_y_d    = in_y_q;
    in_m_d    = in_m_q;
    in_d_d    = in_d_q;
    dir_d     = dir_q;
    cnt_d     = cnt_q;
    ok_d      = ok_q;
    step_ctrl = '{load: 1'b0, advance: 1'b0, dir: dir_q};

    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_y_d     = rsp_y_q;
    rsp_m_d     = rsp_m_q;
    rsp_d_d     = rsp_d_q;
    rsp_ok_d    = rsp_ok_q;

    case (state_q)
      StIdle: begin
        if (req_fire) begin
          in_y_d = req_i.year;
          in_m_d = req_i.month;
          in_d_d = req_i.day;
          dir_d  = req_i.offset_days[gdad_pkg::OffsetW-1] ? gdad_pkg::DirBwd
                                                          : gdad_pkg::DirFwd;
          cnt_d  = mag[gdad_pkg::CountW-1:0];
          ok_d   = 1'b0;
          // Invalid start or hopeless offset: go straight to the result
          state_d = (bad_start || too_far) ? StDone : StSplit;
        end
      end
      StSplit: begin
        if (split_done) begin
          step_ctrl.load = 1'b1;
          state_d        = StCheck;
        end
      end
      StCheck: begin
        state_d = (in_d_q > step_stat.mlen) ? StDone : StWalk;
      end
      StWalk: begin
        if (cnt_q == '0) begin
          ok_d    = 1'b1;
          state_d = StDone;
        end else if ((dir_q == gdad_pkg::DirFwd && step_stat.at_max) ||
                     (dir_q == gdad_pkg::DirBwd && step_stat.at_min)) begin
          // Walk leaves the supported year span
          state_d = StDone;
        end else begin
          step_ctrl.advance = 1'b1;
          cnt_d             = cnt_q - 22'd1;
        end
      end
      StDone: begin
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_ok_d    = ok_q;
          rsp_y_d     = ok_q ? step_y : in_y_q;
          rsp_m_d     = ok_q ? step_m : in_m_q;
          rsp_d_d     = ok_q ? step_d : in_d_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_y_q   <= in_y_d;
    in_m_q   <= in_m_d;
    in_d_q   <= in_d_d;
    dir_q    <= dir_d;
    cnt_q    <= cnt_d;
    ok_q     <= ok_d;
    rsp_y_q  <= rsp_y_d;
    rsp_m_q  <= rsp_m_d;
    rsp_d_q  <= rsp_d_d;
    rsp_ok_q <= rsp_ok_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.new_year  = rsp_y_q;
  assign rsp_o.new_month = rsp_m_q;
  assign rsp_o.new_day   = rsp_d_q;
  assign rsp_o.ok        = rsp_ok_q;

  // A taken request always leaves idle on the next edge
  a_req_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q != StIdle))
    else $error("request accepted but sequencer stayed idle");

  // The remaining day count only shrinks during a walk
  a_cnt_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWalk && $past(state_q) == StWalk) |-> (cnt_q <= $past(cnt_q)))
    else $error("day count grew during walk");

  // A successful result is always a plausible calendar date
  a_ok_date_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ok) |->
      (rsp_o.new_month != 4'd0 && rsp_o.new_month <= gdad_pkg::MonthsPerYear &&
       rsp_o.new_day != 5'd0 && rsp_o.new_year != 14'd0 &&
       rsp_o.new_year <= gdad_pkg::MaxYear))
    else $error("ok result with an impossible date");

  // A failed result echoes the request it belongs to
  a_fail_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_free && !ok_q) |=>
      (rsp_o.new_year == $past(in_y_q) && rsp_o.new_day == $past(in_d_q)))
    else $error("failed result does not echo the request");

endmodule
